/* sv/tlvp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvp_pkg
// shared types, result codes and helper functions of the tlv message parser
// ----------------------------------------------------------------------------
package tlvp_pkg;

	// value bytes kept per record, value register width
	localparam int VALUE_BYTES = 8;
	localparam int VALUE_BITS  = 8 * VALUE_BYTES;

	// result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// result kinds
	localparam logic [2:0] K_HEADER      = 3'd0;
	localparam logic [2:0] K_RECORD      = 3'd1;
	localparam logic [2:0] K_END_OK      = 3'd2;
	localparam logic [2:0] K_END_OVERRUN = 3'd3;
	localparam logic [2:0] K_END_TRAIL   = 3'd4;

	// width match codes
	localparam logic [2:0] W_NONE = 3'd0;
	localparam logic [2:0] W_LEN1 = 3'd1;
	localparam logic [2:0] W_LEN2 = 3'd2;
	localparam logic [2:0] W_LEN4 = 3'd3;
	localparam logic [2:0] W_LEN8 = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  protocol_type;
		logic [7:0]  message_type;
		logic [15:0] declared_payload_bytes;
		logic [7:0]  record_id;
		logic [7:0]  record_length;
		logic [63:0] record_value;
		logic [2:0]  width_match;
		logic        last_of_message;
	} result_t;

	function automatic logic [2:0] match_width(input logic [7:0] len);
		logic [2:0] code;
		unique case (len)
			8'd1:    code = W_LEN1;
			8'd2:    code = W_LEN2;
			8'd4:    code = W_LEN4;
			8'd8:    code = W_LEN8;
			default: code = W_NONE;
		endcase
		if (len > 8'(VALUE_BYTES))
			code = W_NONE;
		return code;
	endfunction

	// record fields only carry data on record results
	function automatic result_t make_result(
		input logic [2:0]            kind,
		input logic [7:0]            proto,
		input logic [7:0]            msg,
		input logic [15:0]           limit,
		input logic [7:0]            rec_id,
		input logic [7:0]            rec_len,
		input logic [VALUE_BITS-1:0] value
	);
		result_t r;
		r.kind                   = kind;
		r.protocol_type          = proto;
		r.message_type           = msg;
		r.declared_payload_bytes = limit;
		r.record_id              = 8'd0;
		r.record_length          = 8'd0;
		r.record_value           = 64'd0;
		r.width_match            = W_NONE;
		r.last_of_message        = (kind >= K_END_OK);
		if (kind == K_RECORD) begin
			r.record_id     = rec_id;
			r.record_length = rec_len;
			r.record_value  = 64'(value);
			r.width_match   = match_width(rec_len);
		end
		return r;
	endfunction

endpackage

/* sv/tlvp_res_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvp_res_fifo
// small result queue, takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
module tlvp_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         wr_cnt,
	input  tlvp_pkg::result_t  wr_data0,
	input  tlvp_pkg::result_t  wr_data1,
	output logic               rd_valid,
	input  logic               rd_ready,
	output tlvp_pkg::result_t  rd_data,
	output logic               room_two
);

	tlvp_pkg::result_t                mem_q [tlvp_pkg::FIFO_DEPTH];
	logic [tlvp_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [tlvp_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [tlvp_pkg::FIFO_CW-1:0]     count_q;
	logic [tlvp_pkg::FIFO_AW-1:0]     wr_ptr_p1;
	logic                             pop;

	assign wr_ptr_p1 = wr_ptr_q + tlvp_pkg::FIFO_AW'(1);
	assign rd_valid  = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];
	assign pop       = rd_valid && rd_ready;
	assign room_two  = (count_q <= tlvp_pkg::FIFO_CW'(tlvp_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (wr_cnt != 2'd0)
			mem_q[wr_ptr_q] <= wr_data0;
		if (wr_cnt == 2'd2)
			mem_q[wr_ptr_p1] <= wr_data1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tlvp_pkg::FIFO_AW'(wr_cnt);
			if (pop)
				rd_ptr_q <= rd_ptr_q + tlvp_pkg::FIFO_AW'(1);
			count_q <= count_q + tlvp_pkg::FIFO_CW'(wr_cnt)
				- tlvp_pkg::FIFO_CW'(pop);
		end
	end

endmodule

/* sv/tlv_message_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_message_parser
// byte-serial parser of a 4-byte header followed by a payload of tlv records
// ----------------------------------------------------------------------------
// The parser takes one message byte per cycle on the slave stream, with tuser
// high on header byte 0 (this also aborts any message in progress). After the
// header it returns a header result, then one result per complete record
// (id, length, big-endian value of the last up to 8 value bytes, width match)
// and a final result with tlast high: end ok, end overrun or end trailing
// byte. Bytes outside a message are dropped with no result. Each byte is
// decoded in the cycle it is taken, by one 16-bit increment plus a 17-bit
// add and compare, straight into a 4-entry result queue that drives the
// master stream one result per cycle while the sink is ready. A byte can
// be taken every cycle while the queue holds two results or fewer; one byte
// yields at most two results (a record or header plus the end result), so
// with a ready sink the input never stalls.
// ----------------------------------------------------------------------------
module tlv_message_parser (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] start_of_message
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // [7:0] protocol_type, [15:8] message_type,
	                                // [31:16] declared_payload_bytes,
	                                // [39:32] record_id, [47:40] record_length,
	                                // [111:48] record_value, [114:112] width_match,
	                                // [119:115] zero
	output logic [2:0]   m_tuser,   // [2:0] kind
	output logic         m_tlast    // last_of_message
);

	// parser phases
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_ID     = 3'd2;
	localparam logic [2:0] PH_LEN    = 3'd3;
	localparam logic [2:0] PH_VAL    = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam int VB = tlvp_pkg::VALUE_BITS;

	// parser state
	logic [2:0]    phase_q,  phase_n;
	logic [1:0]    hdr_cnt_q, hdr_cnt_n;
	logic [7:0]    proto_q,  proto_n;
	logic [7:0]    msg_q,    msg_n;
	logic [15:0]   limit_q,  limit_n;
	logic [15:0]   pos_q,    pos_n;
	logic [7:0]    id_q,     id_n;
	logic [7:0]    len_q,    len_n;
	logic [7:0]    rem_q,    rem_n;
	logic [VB-1:0] value_q,  value_n;

	logic              accept;
	logic [7:0]        b;
	logic [15:0]       pos_inc;
	logic [7:0]        rem_dec;
	logic [16:0]       rec_end;
	logic [1:0]        n_res;
	logic [1:0]        wr_cnt;
	logic [2:0]        kind0, kind1;
	logic              room_two;
	tlvp_pkg::result_t res0, res1, out_res;

	assign b        = s_tdata;
	assign s_tready = room_two;
	assign accept   = s_tvalid && s_tready;
	assign pos_inc  = pos_q + 16'd1;
	assign rem_dec  = rem_q - 8'd1;
	// end of the record announced by a length byte
	assign rec_end  = {1'b0, pos_inc} + {9'd0, b};

	// next state and results of the byte on the input
	always_comb begin
		phase_n   = phase_q;
		hdr_cnt_n = hdr_cnt_q;
		proto_n   = proto_q;
		msg_n     = msg_q;
		limit_n   = limit_q;
		pos_n     = pos_q;
		id_n      = id_q;
		len_n     = len_q;
		rem_n     = rem_q;
		value_n   = value_q;
		n_res     = 2'd0;
		kind0     = tlvp_pkg::K_HEADER;
		kind1     = tlvp_pkg::K_END_OK;
		if (s_tuser) begin
			// start of message clears the state and takes byte 0 as protocol type
			phase_n   = PH_HEADER;
			hdr_cnt_n = 2'd1;
			proto_n   = b;
			msg_n     = 8'd0;
			limit_n   = 16'd0;
			pos_n     = 16'd0;
			id_n      = 8'd0;
			len_n     = 8'd0;
			rem_n     = 8'd0;
			value_n   = '0;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					if (hdr_cnt_q == 2'd1) begin
						msg_n     = b;
						hdr_cnt_n = 2'd2;
					end else if (hdr_cnt_q == 2'd2) begin
						limit_n   = {b, 8'd0};
						hdr_cnt_n = 2'd3;
					end else begin
						limit_n   = {limit_q[15:8], b};
						hdr_cnt_n = 2'd0;
						pos_n     = 16'd0;
						kind0     = tlvp_pkg::K_HEADER;
						if (limit_n == 16'd0) begin
							// empty payload ends on the header byte
							n_res   = 2'd2;
							kind1   = tlvp_pkg::K_END_OK;
							phase_n = PH_DONE;
						end else begin
							n_res   = 2'd1;
							phase_n = PH_ID;
						end
					end
				end
				PH_ID: begin
					id_n  = b;
					pos_n = pos_inc;
					if (pos_inc >= limit_q) begin
						// lone trailing id byte
						n_res   = 2'd1;
						kind0   = tlvp_pkg::K_END_TRAIL;
						phase_n = PH_DONE;
					end else begin
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					len_n   = b;
					pos_n   = pos_inc;
					value_n = '0;
					if (rec_end > {1'b0, limit_q}) begin
						// record overruns the payload, drop it
						pos_n   = limit_q;
						n_res   = 2'd1;
						kind0   = tlvp_pkg::K_END_OVERRUN;
						phase_n = PH_DONE;
					end else if (b == 8'd0) begin
						kind0 = tlvp_pkg::K_RECORD;
						if (pos_inc >= limit_q) begin
							n_res   = 2'd2;
							kind1   = tlvp_pkg::K_END_OK;
							phase_n = PH_DONE;
						end else begin
							n_res   = 2'd1;
							phase_n = PH_ID;
						end
					end else begin
						rem_n   = b;
						phase_n = PH_VAL;
					end
				end
				PH_VAL: begin
					// shift in big-endian, keep the last value bytes only
					value_n = VB'({value_q, b});
					pos_n   = pos_inc;
					rem_n   = rem_dec;
					if (rem_dec == 8'd0) begin
						kind0 = tlvp_pkg::K_RECORD;
						if (pos_inc >= limit_q) begin
							n_res   = 2'd2;
							kind1   = tlvp_pkg::K_END_OK;
							phase_n = PH_DONE;
						end else begin
							n_res   = 2'd1;
							phase_n = PH_ID;
						end
					end
				end
				default: begin
					// idle or done: byte is ignored
				end
			endcase
		end
	end

	// results are built from the updated state
	always_comb begin
		res0 = tlvp_pkg::make_result(kind0, proto_n, msg_n, limit_n, id_n, len_n, value_n);
		res1 = tlvp_pkg::make_result(kind1, proto_n, msg_n, limit_n, id_n, len_n, value_n);
	end

	assign wr_cnt = accept ? n_res : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			hdr_cnt_q <= 2'd0;
			proto_q   <= 8'd0;
			msg_q     <= 8'd0;
			limit_q   <= 16'd0;
			pos_q     <= 16'd0;
			id_q      <= 8'd0;
			len_q     <= 8'd0;
			rem_q     <= 8'd0;
			value_q   <= '0;
		end else if (accept) begin
			phase_q   <= phase_n;
			hdr_cnt_q <= hdr_cnt_n;
			proto_q   <= proto_n;
			msg_q     <= msg_n;
			limit_q   <= limit_n;
			pos_q     <= pos_n;
			id_q      <= id_n;
			len_q     <= len_n;
			rem_q     <= rem_n;
			value_q   <= value_n;
		end
	end

	// result queue toward the master stream
	tlvp_res_fifo u_res_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cnt   (wr_cnt),
		.wr_data0 (res0),
		.wr_data1 (res1),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.rd_data  (out_res),
		.room_two (room_two)
	);

	assign m_tdata = {5'd0,
	                  out_res.width_match,
	                  out_res.record_value,
	                  out_res.record_length,
	                  out_res.record_id,
	                  out_res.declared_payload_bytes,
	                  out_res.message_type,
	                  out_res.protocol_type};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last_of_message;

endmodule
